// ===== design/dqs_pkg.sv =====
// Shared types and codes of the double-ended queue with search.
package dqs_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned ModeW = 3;
  localparam int unsigned StatW = 2;
  localparam int unsigned PosW = 6;
  localparam int unsigned CntW = 7;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_READ       = 3'd4,
    MODE_SEARCH     = 3'd5,
    MODE_CLEAR      = 3'd6
  } mode_t;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_MISS  = 2'd3
  } status_t;

  // What one cell loads at the next edge.
  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_LOAD,
    CELL_LEFT,
    CELL_RIGHT,
    CELL_FRONT
  } cell_op_t;

  // What the whole chain does, as one action shared by all cells.
  typedef enum logic [2:0] {
    CHAIN_HOLD,
    CHAIN_PUSH_FRONT,
    CHAIN_PUSH_BACK,
    CHAIN_POP_FRONT,
    CHAIN_ROTATE
  } chain_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_POST
  } fsm_t;

endpackage

// ===== design/double_ended_queue_with_search_core.sv =====
// Top level of the double-ended queue with search, built as a chain of cells.
//
// The queue holds up to DEPTH signed 32-bit entries in a row of cells; while idle,
// cell i holds the entry at position i from the front. A push at the front shifts
// every cell one place toward the back, a pop at the front shifts one place toward
// the front, a push at the back loads only the cell at the count, and a pop at the
// back changes only the count. Pushes, pops, clear, an out-of-range read and a search
// of an empty queue are done as they are accepted. A read or a search goes through
// the accept cycle, then a scan in which the valid part of the chain rotates
// one place per cycle past cell 0, where the read position or the searched value
// is checked, until the original order is back, and then a post state in which the
// result is registered once the result register is free. One item is worked on at
// a time; the next item is accepted once the result register can take its result.
module double_ended_queue_with_search_core #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dqs_pkg::ModeW-1:0]         in_mode,
  input  logic signed [dqs_pkg::DataW-1:0]  in_value,
  input  logic [dqs_pkg::PosW-1:0]          in_position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dqs_pkg::StatW-1:0]         out_status,
  output logic signed [dqs_pkg::DataW-1:0]  out_data,
  output logic [dqs_pkg::PosW-1:0]          out_found_at,
  output logic [dqs_pkg::CntW-1:0]          out_count
);

  // Width of the entry count, which must be able to hold DEPTH itself.
  localparam int unsigned CW = $clog2(DEPTH + 1);
  // Width for comparing a read position with the count without overflow.
  localparam int unsigned CMPW = ((CW > dqs_pkg::PosW) ? CW : dqs_pkg::PosW) + 1;

  // Control and result registers.
  dqs_pkg::fsm_t                    state_r, state_nxt;
  logic [CW-1:0]                    cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;
  dqs_pkg::status_t                 out_status_r, out_status_nxt;
  logic signed [dqs_pkg::DataW-1:0] out_data_r, out_data_nxt;
  logic [dqs_pkg::PosW-1:0]         out_found_r, out_found_nxt;
  logic [dqs_pkg::CntW-1:0]         out_count_r, out_count_nxt;

  // Scan registers for read and search.
  logic signed [dqs_pkg::DataW-1:0] key_r, key_nxt;
  logic [dqs_pkg::PosW-1:0]         pos_r, pos_nxt;
  logic                             is_search_r, is_search_nxt;
  logic [CW-1:0]                    step_r, step_nxt;
  logic                             hit_r, hit_nxt;
  logic [dqs_pkg::PosW-1:0]         hit_pos_r, hit_pos_nxt;
  logic signed [dqs_pkg::DataW-1:0] hit_data_r, hit_data_nxt;

  dqs_pkg::chain_t                  chain_act;
  dqs_pkg::mode_t                   mode;
  logic                             accept;
  logic                             out_free;
  logic                             full;
  logic                             empty;
  logic [CW-1:0]                    cnt_m1;
  logic [CW+dqs_pkg::CntW-1:0]      cnt_ext;
  logic [CW+dqs_pkg::PosW-1:0]      step_ext;
  logic signed [dqs_pkg::DataW-1:0] cell_q [DEPTH];

  assign mode     = dqs_pkg::mode_t'(in_mode);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != dqs_pkg::FSM_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;
  assign full     = (cnt_r == CW'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign cnt_m1   = cnt_r - CW'(1);
  // The count after the request, trimmed to the output field.
  assign cnt_ext  = {{dqs_pkg::CntW{1'b0}}, cnt_nxt};
  // The scan step is the position from the front now sitting in cell 0.
  assign step_ext = {{dqs_pkg::PosW{1'b0}}, step_r};

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_found_nxt  = out_found_r;
    out_count_nxt  = out_count_r;
    key_nxt        = key_r;
    pos_nxt        = pos_r;
    is_search_nxt  = is_search_r;
    step_nxt       = step_r;
    hit_nxt        = hit_r;
    hit_pos_nxt    = hit_pos_r;
    hit_data_nxt   = hit_data_r;
    chain_act      = dqs_pkg::CHAIN_HOLD;

    unique case (state_r)
      dqs_pkg::FSM_IDLE: begin
        if (accept) begin
          // Most requests finish at once; the default result is a plain success.
          out_valid_nxt  = 1'b1;
          out_status_nxt = dqs_pkg::STAT_OK;
          out_data_nxt   = '0;
          out_found_nxt  = '0;
          unique case (mode)
            dqs_pkg::MODE_PUSH_FRONT: begin
              if (full) begin
                out_status_nxt = dqs_pkg::STAT_FULL;
              end else begin
                chain_act = dqs_pkg::CHAIN_PUSH_FRONT;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            dqs_pkg::MODE_PUSH_BACK: begin
              if (full) begin
                out_status_nxt = dqs_pkg::STAT_FULL;
              end else begin
                chain_act = dqs_pkg::CHAIN_PUSH_BACK;
                cnt_nxt   = cnt_r + CW'(1);
              end
            end
            dqs_pkg::MODE_POP_FRONT: begin
              if (empty) begin
                out_status_nxt = dqs_pkg::STAT_EMPTY;
              end else begin
                chain_act = dqs_pkg::CHAIN_POP_FRONT;
                cnt_nxt   = cnt_m1;
              end
            end
            dqs_pkg::MODE_POP_BACK: begin
              if (empty) begin
                out_status_nxt = dqs_pkg::STAT_EMPTY;
              end else begin
                cnt_nxt = cnt_m1;
              end
            end
            dqs_pkg::MODE_READ: begin
              if (CMPW'(in_position) >= CMPW'(cnt_r)) begin
                out_status_nxt = dqs_pkg::STAT_MISS;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = dqs_pkg::FSM_SCAN;
                is_search_nxt = 1'b0;
              end
            end
            dqs_pkg::MODE_SEARCH: begin
              if (empty) begin
                out_status_nxt = dqs_pkg::STAT_MISS;
              end else begin
                out_valid_nxt = 1'b0;
                state_nxt     = dqs_pkg::FSM_SCAN;
                is_search_nxt = 1'b1;
              end
            end
            dqs_pkg::MODE_CLEAR: begin
              cnt_nxt = '0;
            end
            default: begin
              // The unused mode code changes nothing.
            end
          endcase
          key_nxt       = in_value;
          pos_nxt       = in_position;
          step_nxt      = '0;
          hit_nxt       = 1'b0;
          hit_pos_nxt   = '0;
          hit_data_nxt  = '0;
          out_count_nxt = cnt_ext[dqs_pkg::CntW-1:0];
        end
      end

      dqs_pkg::FSM_SCAN: begin
        // Cell 0 holds the entry at position step_r; check it, then rotate once.
        chain_act = dqs_pkg::CHAIN_ROTATE;
        if (is_search_r) begin
          if (!hit_r && (cell_q[0] == key_r)) begin
            hit_nxt     = 1'b1;
            hit_pos_nxt = step_ext[dqs_pkg::PosW-1:0];
          end
        end else if (CMPW'(step_r) == CMPW'(pos_r)) begin
          hit_data_nxt = cell_q[0];
        end
        step_nxt = step_r + CW'(1);
        if (step_r == cnt_m1) begin
          state_nxt = dqs_pkg::FSM_POST;
        end
      end

      dqs_pkg::FSM_POST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_count_nxt = cnt_ext[dqs_pkg::CntW-1:0];
          if (is_search_r) begin
            out_status_nxt = hit_r ? dqs_pkg::STAT_OK : dqs_pkg::STAT_MISS;
            out_data_nxt   = '0;
            out_found_nxt  = hit_r ? hit_pos_r : '0;
          end else begin
            out_status_nxt = dqs_pkg::STAT_OK;
            out_data_nxt   = hit_data_r;
            out_found_nxt  = '0;
          end
          state_nxt = dqs_pkg::FSM_IDLE;
        end
      end

      default: begin
        state_nxt = dqs_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dqs_pkg::FSM_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_data_r   <= out_data_nxt;
    out_found_r  <= out_found_nxt;
    out_count_r  <= out_count_nxt;
    key_r        <= key_nxt;
    pos_r        <= pos_nxt;
    is_search_r  <= is_search_nxt;
    step_r       <= step_nxt;
    hit_r        <= hit_nxt;
    hit_pos_r    <= hit_pos_nxt;
    hit_data_r   <= hit_data_nxt;
  end

  // The chain. Each cell decides from the chain action and its own place what to
  // load. During a rotation the last valid cell takes the front entry, so the
  // valid part of the chain turns as a ring while cells past the count take junk.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    dqs_pkg::cell_op_t                op;
    logic signed [dqs_pkg::DataW-1:0] left_d;
    logic signed [dqs_pkg::DataW-1:0] right_d;

    if (i == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_mid_left
      assign left_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_d = cell_q[i];
    end else begin : g_mid_right
      assign right_d = cell_q[i+1];
    end

    always_comb begin
      unique case (chain_act)
        dqs_pkg::CHAIN_PUSH_FRONT: begin
          op = (i == 0) ? dqs_pkg::CELL_LOAD : dqs_pkg::CELL_LEFT;
        end
        dqs_pkg::CHAIN_PUSH_BACK: begin
          op = (cnt_r == CW'(i)) ? dqs_pkg::CELL_LOAD : dqs_pkg::CELL_HOLD;
        end
        dqs_pkg::CHAIN_POP_FRONT: begin
          op = dqs_pkg::CELL_RIGHT;
        end
        dqs_pkg::CHAIN_ROTATE: begin
          op = (cnt_m1 == CW'(i)) ? dqs_pkg::CELL_FRONT : dqs_pkg::CELL_RIGHT;
        end
        default: begin
          op = dqs_pkg::CELL_HOLD;
        end
      endcase
    end

    dqs_cell u_cell (
      .clk        (clk),
      .op         (op),
      .load_data  (in_value),
      .left_data  (left_d),
      .right_data (right_d),
      .front_data (cell_q[0]),
      .data_q     (cell_q[i])
    );
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_data     = out_data_r;
  assign out_found_at = out_found_r;
  assign out_count    = out_count_r;

endmodule

// ===== design/dqs_cell.sv =====
// One storage cell of the queue chain: holds one entry and loads a new value, a neighbor's or the front entry.
module dqs_cell (
  input  logic                                 clk,
  input  dqs_pkg::cell_op_t                    op,
  input  logic signed [dqs_pkg::DataW-1:0]     load_data,
  input  logic signed [dqs_pkg::DataW-1:0]     left_data,
  input  logic signed [dqs_pkg::DataW-1:0]     right_data,
  input  logic signed [dqs_pkg::DataW-1:0]     front_data,
  output logic signed [dqs_pkg::DataW-1:0]     data_q
);

  logic signed [dqs_pkg::DataW-1:0] data_r;
  logic signed [dqs_pkg::DataW-1:0] data_nxt;

  always_comb begin
    unique case (op)
      dqs_pkg::CELL_LOAD:  data_nxt = load_data;
      dqs_pkg::CELL_LEFT:  data_nxt = left_data;
      dqs_pkg::CELL_RIGHT: data_nxt = right_data;
      dqs_pkg::CELL_FRONT: data_nxt = front_data;
      default:             data_nxt = data_r;
    endcase
  end

  // Entries are undefined until written, so the cell has no reset.
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;

endmodule
